>>> rtl/pdbsp_pkg.sv
package pdbsp_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 512;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_SAMPLE_PERIOD = 2'd0;

  typedef enum logic [1:0] {
    FN_RECORD = 2'd0,
    FN_RING   = 2'd1,
    FN_BLOCK  = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FETCH
  } ctrl_state_e;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic exec_en;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_valid;
    logic out_free;
  } ctrl_status_t;

endpackage

>>> rtl/pdbsp_in_if.sv
interface pdbsp_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [pdbsp_pkg::SAMPLE_W-1:0] sample_in;
  logic                                block_sel;
  logic [pdbsp_pkg::TIME_W-1:0]        time_us;

  modport source (output valid, func, sample_in, block_sel, time_us, input ready);
  modport sink (input valid, func, sample_in, block_sel, time_us, output ready);
endinterface

>>> rtl/pdbsp_out_if.sv
interface pdbsp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdbsp_pkg::SAMPLE_W-1:0] sample_out;
  logic                                  half_full;

  modport source (output valid, sample_out, half_full, input ready);
  modport sink (input valid, sample_out, half_full, output ready);
endinterface

>>> rtl/pdbsp_ctrl.sv
module pdbsp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pdbsp_pkg::ctrl_status_t status_i,
  output pdbsp_pkg::ctrl_cmd_t    cmd_o
);
  import pdbsp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (status_i.in_valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_FETCH;
      end
      S_FETCH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_CLEAR: cmd_o.clr_en   = 1'b1;
      S_IDLE:  cmd_o.accept   = 1'b1;
      S_EXEC:  cmd_o.exec_en  = 1'b1;
      S_FETCH: cmd_o.load_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded into an occupied output register");

  a_exec_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec_en |-> $past(cmd_o.accept && status_i.in_valid))
    else $error("execution without an accepted request");

endmodule

>>> rtl/pdbsp_dp.sv
module pdbsp_dp #(
  parameter int unsigned BUFFER_DEPTH = pdbsp_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pdbsp_pkg::ctrl_cmd_t            cmd_i,
  output pdbsp_pkg::ctrl_status_t         status_o,
  pdbsp_in_if.sink                        in_if,
  pdbsp_out_if.source                     out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdbsp_pkg::PADDR_W-1:0]   paddr,
  input  logic [pdbsp_pkg::PDATA_W-1:0]   pwdata,
  output logic [pdbsp_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import pdbsp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned POS_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned HALF   = BUFFER_DEPTH / 2;
  localparam logic [POS_W-1:0] HALF_P  = POS_W'(HALF);
  localparam logic [POS_W-1:0] TWO_H_P = POS_W'(2 * HALF);
  localparam logic [POS_W:0]   DEPTH_W = (POS_W + 1)'(BUFFER_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(BUFFER_DEPTH - 1);

  logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  logic [TIME_W-1:0]   period_q;
  logic [ADDR_W-1:0]   clr_cnt_q;

  func_e               func_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                sel_q;
  logic [TIME_W-1:0]   time_q;
  logic                adv_q;

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [TIME_W-1:0]   last_q, last_d;
  logic                res_zero_q, res_zero_d;
  logic                res_full_q, res_full_d;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] sample_out_q;
  logic                half_full_q;

  logic                wr_req, rd_req;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [TIME_W-1:0]   elapsed;
  logic                in_fire;

  logic [POS_W-1:0]    rec_end_m1;
  logic [POS_W:0]      pos_inc;
  logic [POS_W:0]      ring_next;
  logic [POS_W-1:0]    blk_start, blk_end, blk_pos;

  assign pready = 1'b1;
  assign prdata = period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
    end else if (psel && penable && pwrite && (paddr == ADDR_SAMPLE_PERIOD)) begin
      period_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign in_if.ready = cmd_i.accept;
  assign in_fire     = cmd_i.accept && in_if.valid;
  assign elapsed     = in_if.time_us - last_q;

  assign status_o.clear_done = cmd_i.clr_en && (clr_cnt_q == LAST_A);
  assign status_o.in_valid   = in_if.valid;
  assign status_o.out_free   = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= func_e'(in_if.func);
      sample_q <= in_if.sample_in;
      sel_q    <= in_if.block_sel;
      time_q   <= in_if.time_us;
      adv_q    <= (elapsed >= period_q);
    end
  end

  assign rec_end_m1 = (pos_q >= HALF_P) ? (TWO_H_P - 1'b1) : (HALF_P - 1'b1);
  assign pos_inc    = {1'b0, pos_q} + 1'b1;
  assign ring_next  = (pos_inc >= DEPTH_W) ? (pos_inc - DEPTH_W) : pos_inc;
  assign blk_start  = sel_q ? HALF_P : '0;
  assign blk_end    = sel_q ? TWO_H_P : HALF_P;
  assign blk_pos    = ((pos_q < blk_start) || (pos_q > blk_end)) ? blk_start : pos_q;

  always_comb begin
    pos_d      = pos_q;
    last_d     = last_q;
    wr_req     = 1'b0;
    rd_req     = 1'b0;
    rd_addr    = pos_q[ADDR_W-1:0];
    res_zero_d = 1'b1;
    res_full_d = 1'b0;
    if (cmd_i.exec_en && (func_q != FN_NONE)) begin
      if (period_q == '0) begin
        last_d = time_q;
      end else begin
        case (func_q)
          FN_RECORD: begin
            if (pos_q < TWO_H_P) begin
              wr_req     = 1'b1;
              res_full_d = (pos_q == rec_end_m1);
              if (adv_q) begin
                last_d = time_q;
                if (pos_q < rec_end_m1) pos_d = pos_inc[POS_W-1:0];
              end
            end
          end
          FN_RING: begin
            if (adv_q) begin
              last_d     = time_q;
              pos_d      = ring_next[POS_W-1:0];
              rd_addr    = ring_next[ADDR_W-1:0];
              rd_req     = 1'b1;
              res_zero_d = 1'b0;
            end else if ({1'b0, pos_q} < DEPTH_W) begin
              rd_req     = 1'b1;
              res_zero_d = 1'b0;
            end
          end
          FN_BLOCK: begin
            pos_d = blk_pos;
            if (blk_pos < blk_end) begin
              rd_addr    = blk_pos[ADDR_W-1:0];
              rd_req     = 1'b1;
              res_zero_d = 1'b0;
              if (adv_q) begin
                last_d = time_q;
                pos_d  = blk_pos + 1'b1;
              end
            end
          end
          default: begin
            pos_d = pos_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      last_q <= '0;
    end else begin
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_en) begin
      res_zero_q <= res_zero_d;
      res_full_q <= res_full_d;
    end
  end

  assign mem_we    = cmd_i.clr_en || wr_req;
  assign mem_waddr = cmd_i.clr_en ? clr_cnt_q : pos_q[ADDR_W-1:0];
  assign mem_wdata = cmd_i.clr_en ? '0 : sample_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_req) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_out_q <= res_zero_q ? '0 : rdata_q;
      half_full_q  <= res_full_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = sample_out_q;
  assign out_if.half_full  = half_full_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} <= DEPTH_W)
    else $error("position beyond store depth");

  a_none_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec_en && (func_q == FN_NONE) |=> $stable(pos_q) && $stable(last_q))
    else $error("unused selector changed state");

  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cmd_i.clr_en || (cmd_i.exec_en && (func_q == FN_RECORD))))
    else $error("store written outside clear or record");

endmodule

>>> rtl/paced_double_buffer_sample_player.sv
// A request is accepted, then executed with at most one store access, then
// its result is loaded into the output register from the registered store
// read once that register is free; no new request is taken until then.
// Reset: position, last advance time and sample period clear at once; the
// store is then zeroed by a sweep over all BUFFER_DEPTH entries before the
// first request is taken.
module paced_double_buffer_sample_player #(
  parameter int unsigned BUFFER_DEPTH = pdbsp_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pdbsp_in_if.sink                      in_if,
  pdbsp_out_if.source                   out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdbsp_pkg::PADDR_W-1:0] paddr,
  input  logic [pdbsp_pkg::PDATA_W-1:0] pwdata,
  output logic [pdbsp_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import pdbsp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  pdbsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  pdbsp_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_if    (in_if),
    .out_if   (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

endmodule
